@@ src/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed delay
`define VTA_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

@@ src/vta_pkg.sv @@
// types, constants and codes of the tuple alu
`timescale 1ns / 1ps

package vta_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int W           = 32;
    localparam int SUM_W       = 2 * W + 4;
    localparam int SQ_W        = 2 * W;
    localparam int SQRT_REM_W  = W + 2;
    localparam int NUM_W       = W + FRAC_BITS;
    localparam int SQRT_STAGES = W;
    localparam int DIV_STAGES  = NUM_W;
    localparam int N_MUL       = 6;
    localparam int PIPE_LAT    = 4 + SQRT_STAGES + 1 + DIV_STAGES + 1;

    localparam int EPS_W  = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
    localparam logic REG_EPSILON = 1'b0;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI   = (SUM_W'(1) << (W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO   = -(SUM_W'(1) << (W - 1));

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_DOT   = 4'd5,
        OP_CROSS = 4'd6,
        OP_MAG   = 4'd7,
        OP_NORM  = 4'd8,
        OP_EQUAL = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_DIV0 = 2'd1,
        ERR_OVF  = 2'd2
    } t_err;

    typedef struct packed {
        logic [3:0]          req_type;
        logic signed [W-1:0] a_x;
        logic signed [W-1:0] a_y;
        logic signed [W-1:0] a_z;
        logic signed [W-1:0] a_w;
        logic signed [W-1:0] b_x;
        logic signed [W-1:0] b_y;
        logic signed [W-1:0] b_z;
        logic signed [W-1:0] b_w;
        logic signed [W-1:0] scalar_in;
    } t_req;

    typedef struct packed {
        logic signed [W-1:0] r_x;
        logic signed [W-1:0] r_y;
        logic signed [W-1:0] r_z;
        logic signed [W-1:0] r_w;
        logic signed [W-1:0] scalar_out;
        logic                equal_flag;
        logic [1:0]          error_code;
    } t_rsp;

    // context riding alongside the square root
    typedef struct packed {
        logic [3:0]          op;
        logic [3:0][W-1:0]   a;
        logic [W-1:0]        s;
        logic [3:0][W-1:0]   r;
        logic [W-1:0]        sc;
        logic                eq;
        logic                ovf;
    } t_ctx1;

    // context riding alongside the dividers
    typedef struct packed {
        logic [3:0]          op;
        logic [3:0][W-1:0]   r;
        logic [W-1:0]        sc;
        logic                eq;
        logic                ovf;
        logic [3:0]          neg;
        logic [3:0]          aneg;
        logic                dz;
        logic [W-1:0]        mag;
    } t_ctx2;

endpackage

@@ src/vta_sqrt.sv @@
// pipelined floor square root, one root bit per stage
`timescale 1ns / 1ps

module vta_sqrt (
    input  logic                      i_clk,
    input  logic [vta_pkg::SQ_W-1:0]  i_rad,
    output logic [vta_pkg::W-1:0]     o_root
);
    import vta_pkg::*;

    logic [SQ_W-1:0]       r_val  [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] r_rem  [SQRT_STAGES];
    logic [W-1:0]          r_root [SQRT_STAGES];
    logic [SQ_W-1:0]       n_val  [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] n_rem  [SQRT_STAGES];
    logic [W-1:0]          n_root [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [SQ_W-1:0]       pv;
        logic [SQRT_REM_W-1:0] prem;
        logic [W-1:0]          proot;
        logic [SQRT_REM_W+1:0] shf;
        logic [SQRT_REM_W+1:0] trial;

        if (k == 0) begin : g_first
            assign pv    = i_rad;
            assign prem  = '0;
            assign proot = '0;
        end else begin : g_next
            assign pv    = r_val[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
        end

        always_comb begin
            shf      = {prem, pv[SQ_W-1 -: 2]};
            trial    = (SQRT_REM_W + 2)'({proot, 2'b01});
            n_val[k] = pv << 2;
            if (shf >= trial) begin
                n_rem[k]  = SQRT_REM_W'(shf - trial);
                n_root[k] = {proot[W-2:0], 1'b1};
            end else begin
                n_rem[k]  = SQRT_REM_W'(shf);
                n_root[k] = {proot[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_val[k]  <= n_val[k];
            r_rem[k]  <= n_rem[k];
            r_root[k] <= n_root[k];
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

@@ src/vta_div.sv @@
// pipelined unsigned restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module vta_div (
    input  logic                       i_clk,
    input  logic [vta_pkg::NUM_W-1:0]  i_num,
    input  logic [vta_pkg::W-1:0]      i_den,
    output logic [vta_pkg::NUM_W-1:0]  o_quo
);
    import vta_pkg::*;

    logic [W-1:0]     r_rem [DIV_STAGES];
    logic [NUM_W-1:0] r_acc [DIV_STAGES];
    logic [W-1:0]     r_den [DIV_STAGES];
    logic [W-1:0]     n_rem [DIV_STAGES];
    logic [NUM_W-1:0] n_acc [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [W-1:0]     prem;
        logic [NUM_W-1:0] pacc;
        logic [W-1:0]     pden;
        logic [W:0]       shf;

        if (k == 0) begin : g_first
            assign prem = '0;
            assign pacc = i_num;
            assign pden = i_den;
        end else begin : g_next
            assign prem = r_rem[k-1];
            assign pacc = r_acc[k-1];
            assign pden = r_den[k-1];
        end

        always_comb begin
            shf = {prem, pacc[NUM_W-1]};
            if (shf >= {1'b0, pden}) begin
                n_rem[k] = W'(shf - {1'b0, pden});
                n_acc[k] = {pacc[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = W'(shf);
                n_acc[k] = {pacc[NUM_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem[k];
            r_acc[k] <= n_acc[k];
            r_den[k] <= pden;
        end
    end

    assign o_quo = r_acc[DIV_STAGES-1];

endmodule

@@ src/vector_tuple_alu.sv @@
// top level of the homogeneous tuple alu
// every start that is taken gives one result strobe, for every opcode
// throughput: one beat per cycle, busy is always low
// the pipeline runs through 32 square root stages and 48 divider stages in series
// reset clears the valid bits and sets epsilon to 1; results are never held off
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_tuple_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  vta_pkg::t_req                 i_req,
    output logic                          o_strobe,
    output vta_pkg::t_rsp                 o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vta_pkg::ADDR_W-1:0]    paddr,
    input  logic [vta_pkg::DATA_W-1:0]    pwdata,
    output logic [vta_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import vta_pkg::*;

    function automatic logic [W:0] sat_w(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI) begin
            return {1'b1, W'(SAT_HI)};
        end else if (v < SAT_LO) begin
            return {1'b1, W'(SAT_LO)};
        end
        return {1'b0, W'(v)};
    endfunction

    function automatic logic signed [SUM_W-1:0] sx(input logic [W-1:0] v);
        return SUM_W'($signed(v));
    endfunction

    function automatic logic [W-1:0] abs_w(input logic [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    function automatic logic [3:0][W-1:0] req_a(input t_req q);
        return {q.a_w, q.a_z, q.a_y, q.a_x};
    endfunction

    function automatic logic [3:0][W-1:0] req_b(input t_req q);
        return {q.b_w, q.b_z, q.b_y, q.b_x};
    endfunction

    // configuration
    logic [EPS_W-1:0] r_epsilon;
    logic [EPS_W-1:0] n_epsilon;
    logic             cfg_wr;
    logic             cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1];
    assign prdata  = (cfg_idx == REG_EPSILON) ? DATA_W'(r_epsilon) : '0;

    always_comb begin
        n_epsilon = r_epsilon;
        if (cfg_wr && cfg_idx == REG_EPSILON) begin
            n_epsilon = pwdata[EPS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon <= EPS_RESET;
        end else begin
            r_epsilon <= n_epsilon;
        end
    end

    // stage 1: input register
    logic r1_valid;
    t_req r1_req;

    // stage 2: products
    logic                     r2_valid;
    t_req                     r2_req;
    logic signed [2*W-1:0]    r2_prod [N_MUL];
    logic signed [2*W-1:0]    n2_prod [N_MUL];
    logic signed [W-1:0]      m_a [N_MUL];
    logic signed [W-1:0]      m_b [N_MUL];
    logic [3:0][W-1:0]        a1;
    logic [3:0][W-1:0]        b1;

    assign a1 = req_a(r1_req);
    assign b1 = req_b(r1_req);

    always_comb begin
        for (int i = 0; i < N_MUL; i++) begin
            m_a[i] = '0;
            m_b[i] = '0;
        end
        case (t_op'(r1_req.req_type))
            OP_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    m_a[i] = $signed(a1[i]);
                    m_b[i] = r1_req.scalar_in;
                end
            end
            OP_DOT: begin
                for (int i = 0; i < 4; i++) begin
                    m_a[i] = $signed(a1[i]);
                    m_b[i] = $signed(b1[i]);
                end
            end
            OP_CROSS: begin
                m_a[0] = $signed(a1[1]); m_b[0] = $signed(b1[2]);
                m_a[1] = $signed(a1[2]); m_b[1] = $signed(b1[1]);
                m_a[2] = $signed(a1[2]); m_b[2] = $signed(b1[0]);
                m_a[3] = $signed(a1[0]); m_b[3] = $signed(b1[2]);
                m_a[4] = $signed(a1[0]); m_b[4] = $signed(b1[1]);
                m_a[5] = $signed(a1[1]); m_b[5] = $signed(b1[0]);
            end
            OP_MAG, OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    m_a[i] = $signed(a1[i]);
                    m_b[i] = $signed(a1[i]);
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < N_MUL; i++) begin
            n2_prod[i] = m_a[i] * m_b[i];
        end
    end

    // stage 3: sums and equality
    logic                     r3_valid;
    t_req                     r3_req;
    logic signed [SUM_W-1:0]  r3_sum [4];
    logic                     r3_rnd;
    logic [SQ_W-1:0]          r3_sq;
    logic                     r3_eq;
    logic signed [SUM_W-1:0]  n3_sum [4];
    logic                     n3_rnd;
    logic [SQ_W-1:0]          n3_sq;
    logic                     n3_eq;
    logic [3:0][W-1:0]        a2;
    logic [3:0][W-1:0]        b2;

    assign a2 = req_a(r2_req);
    assign b2 = req_b(r2_req);

    always_comb begin
        logic signed [W:0] d;
        logic [W:0]        absd;
        for (int i = 0; i < 4; i++) begin
            n3_sum[i] = '0;
        end
        n3_rnd = 1'b0;
        n3_sq  = '0;
        n3_eq  = 1'b0;
        d      = '0;
        absd   = '0;
        case (t_op'(r2_req.req_type))
            OP_ADD: begin
                for (int i = 0; i < 4; i++) n3_sum[i] = sx(a2[i]) + sx(b2[i]);
            end
            OP_SUB: begin
                for (int i = 0; i < 4; i++) n3_sum[i] = sx(a2[i]) - sx(b2[i]);
            end
            OP_NEG: begin
                for (int i = 0; i < 4; i++) n3_sum[i] = -sx(a2[i]);
            end
            OP_SCALE: begin
                n3_rnd = 1'b1;
                for (int i = 0; i < 4; i++) n3_sum[i] = SUM_W'(r2_prod[i]);
            end
            OP_DOT: begin
                n3_rnd    = 1'b1;
                n3_sum[0] = SUM_W'(r2_prod[0]) + SUM_W'(r2_prod[1])
                          + SUM_W'(r2_prod[2]) + SUM_W'(r2_prod[3]);
            end
            OP_CROSS: begin
                n3_rnd = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    n3_sum[i] = SUM_W'(r2_prod[2*i]) - SUM_W'(r2_prod[2*i+1]);
                end
            end
            OP_MAG, OP_NORM: begin
                n3_sq = SQ_W'(r2_prod[0]) + SQ_W'(r2_prod[1]) + SQ_W'(r2_prod[2]);
            end
            OP_EQUAL: begin
                n3_eq = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    d    = {a2[i][W-1], a2[i]} - {b2[i][W-1], b2[i]};
                    absd = d[W] ? (W+1)'(-d) : (W+1)'(d);
                    if (!(absd < (W+1)'(r_epsilon))) n3_eq = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // stage 4: rounding and saturation
    logic             r4_valid;
    t_ctx1            r4_ctx;
    logic [SQ_W-1:0]  r4_sq;
    t_ctx1            n4_ctx;

    always_comb begin
        logic signed [SUM_W-1:0] v;
        logic [W:0]              t [4];
        for (int i = 0; i < 4; i++) begin
            v    = r3_rnd ? ((r3_sum[i] + RND_HALF) >>> FRAC_BITS) : r3_sum[i];
            t[i] = sat_w(v);
        end
        n4_ctx    = '0;
        n4_ctx.op = r3_req.req_type;
        n4_ctx.a  = req_a(r3_req);
        n4_ctx.s  = r3_req.scalar_in;
        case (t_op'(r3_req.req_type))
            OP_ADD, OP_SUB, OP_NEG, OP_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    n4_ctx.r[i] = t[i][W-1:0];
                    n4_ctx.ovf  = n4_ctx.ovf | t[i][W];
                end
            end
            OP_DOT: begin
                n4_ctx.sc  = t[0][W-1:0];
                n4_ctx.ovf = t[0][W];
            end
            OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n4_ctx.r[i] = t[i][W-1:0];
                    n4_ctx.ovf  = n4_ctx.ovf | t[i][W];
                end
            end
            OP_EQUAL: begin
                n4_ctx.eq = r3_eq;
            end
            default: begin
            end
        endcase
    end

    // square root and its context line
    logic [W-1:0] sq_root;
    t_ctx1        r_ctx1 [SQRT_STAGES];
    logic         r_v1   [SQRT_STAGES];

    vta_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r4_sq),
        .o_root (sq_root)
    );

    // stage 5: divider operands
    logic             r5_valid;
    t_ctx2            r5_ctx;
    logic [NUM_W-1:0] r5_num [4];
    logic [W-1:0]     r5_den;
    t_ctx2            n5_ctx;
    logic [NUM_W-1:0] n5_num [4];
    logic [W-1:0]     n5_den;
    t_ctx1            c1;

    assign c1 = r_ctx1[SQRT_STAGES-1];

    always_comb begin
        logic is_div;
        is_div     = (t_op'(c1.op) == OP_DIV);
        n5_den     = is_div ? abs_w(c1.s) : sq_root;
        n5_ctx     = '0;
        n5_ctx.op  = c1.op;
        n5_ctx.r   = c1.r;
        n5_ctx.sc  = c1.sc;
        n5_ctx.eq  = c1.eq;
        n5_ctx.ovf = c1.ovf;
        n5_ctx.dz  = (n5_den == '0);
        n5_ctx.mag = sq_root;
        for (int i = 0; i < 4; i++) begin
            n5_num[i]      = NUM_W'(abs_w(c1.a[i])) << FRAC_BITS;
            n5_ctx.aneg[i] = c1.a[i][W-1];
            n5_ctx.neg[i]  = c1.a[i][W-1] ^ (is_div & c1.s[W-1]);
        end
    end

    // dividers and their context line
    logic [NUM_W-1:0] quo   [4];
    t_ctx2            r_ctx2 [DIV_STAGES];
    logic             r_v2   [DIV_STAGES];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        vta_div u_div (
            .i_clk (i_clk),
            .i_num (r5_num[g]),
            .i_den (r5_den),
            .o_quo (quo[g])
        );
    end

    // stage 6: result
    logic  r_out_valid;
    t_rsp  r_out;
    t_rsp  n_out;
    t_ctx2 c2;

    assign c2 = r_ctx2[DIV_STAGES-1];

    always_comb begin
        logic signed [NUM_W:0] qs;
        logic [W:0]            t [4];
        logic [W-1:0]          dzv [4];
        logic [W:0]            tm;
        logic [3:0][W-1:0]     r;
        logic [W-1:0]          sc;
        logic                  ovf;
        logic                  dz;
        for (int i = 0; i < 4; i++) begin
            qs     = c2.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
            t[i]   = sat_w(SUM_W'(qs));
            dzv[i] = c2.aneg[i] ? W'(SAT_LO) : W'(SAT_HI);
        end
        tm  = sat_w(SUM_W'(c2.mag));
        r   = c2.r;
        sc  = c2.sc;
        ovf = c2.ovf;
        dz  = 1'b0;
        case (t_op'(c2.op))
            OP_DIV: begin
                dz = c2.dz;
                for (int i = 0; i < 4; i++) begin
                    r[i] = c2.dz ? dzv[i] : t[i][W-1:0];
                    ovf  = ovf | (t[i][W] & !c2.dz);
                end
            end
            OP_NORM: begin
                dz   = c2.dz;
                r[3] = '0;
                for (int i = 0; i < 3; i++) begin
                    r[i] = c2.dz ? dzv[i] : t[i][W-1:0];
                    ovf  = ovf | (t[i][W] & !c2.dz);
                end
            end
            OP_MAG: begin
                sc  = tm[W-1:0];
                ovf = tm[W];
            end
            default: begin
            end
        endcase
        n_out.r_x        = r[0];
        n_out.r_y        = r[1];
        n_out.r_z        = r[2];
        n_out.r_w        = r[3];
        n_out.scalar_out = sc;
        n_out.equal_flag = c2.eq;
        n_out.error_code = dz ? ERR_DIV0 : (ovf ? ERR_OVF : ERR_OK);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r1_req <= i_req;
        r2_req <= r1_req;
        for (int i = 0; i < N_MUL; i++) r2_prod[i] <= n2_prod[i];
        r3_req <= r2_req;
        for (int i = 0; i < 4; i++) r3_sum[i] <= n3_sum[i];
        r3_rnd <= n3_rnd;
        r3_sq  <= n3_sq;
        r3_eq  <= n3_eq;
        r4_ctx <= n4_ctx;
        r4_sq  <= r3_sq;
        r_ctx1[0] <= r4_ctx;
        for (int k = 1; k < SQRT_STAGES; k++) r_ctx1[k] <= r_ctx1[k-1];
        r5_ctx <= n5_ctx;
        r5_den <= n5_den;
        for (int i = 0; i < 4; i++) r5_num[i] <= n5_num[i];
        r_ctx2[0] <= r5_ctx;
        for (int k = 1; k < DIV_STAGES; k++) r_ctx2[k] <= r_ctx2[k-1];
        r_out <= n_out;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SQRT_STAGES; k++) r_v1[k] <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) r_v2[k] <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r_v1[0]  <= r4_valid;
            for (int k = 1; k < SQRT_STAGES; k++) r_v1[k] <= r_v1[k-1];
            r5_valid <= r_v1[SQRT_STAGES-1];
            r_v2[0]  <= r5_valid;
            for (int k = 1; k < DIV_STAGES; k++) r_v2[k] <= r_v2[k-1];
            r_out_valid <= r_v2[DIV_STAGES-1];
        end
    end

    assign o_strobe = r_out_valid;
    assign o_rsp    = r_out;

    `VTA_ASSERT_DLY(a_fixed_latency, i_clk, i_rst_n, start && !busy, PIPE_LAT, o_strobe, "accepted beat gave no result at the pipeline latency")
    `VTA_ASSERT_IMP(a_no_extra_beat, i_clk, i_rst_n, o_strobe, $past(start && !busy, PIPE_LAT), "result beat without an accepted request")
    `VTA_ASSERT_IMP(a_div0_source, i_clk, i_rst_n, o_strobe && o_rsp.error_code == ERR_DIV0, $past(i_req.req_type, PIPE_LAT) == OP_DIV || $past(i_req.req_type, PIPE_LAT) == OP_NORM, "divide by zero from an opcode that does not divide")
    `VTA_ASSERT_IMP(a_equal_clean, i_clk, i_rst_n, o_strobe && o_rsp.equal_flag, o_rsp.error_code == ERR_OK && o_rsp.scalar_out == '0, "equal result carries an error or a scalar")

endmodule
